// ----- sv/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int CELL_AW = $clog2(CELL_COUNT);

   // Field widths
   localparam int MODE_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int COLOUR_W = 4;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;
   localparam int CELL_W   = 16;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_LAST  = 8'd127;

   // Sweep bounds
   localparam logic [CELL_AW-1:0] SCROLL_END = CELL_AW'(CELL_COUNT - COLUMNS);
   localparam logic [CELL_AW-1:0] LAST_CELL  = CELL_AW'(CELL_COUNT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL,
      ST_DONE
   } tcw_state_type;

   typedef struct packed {
      logic                valid;
      logic [CURSOR_W-1:0] cursor;
      logic [CELL_W-1:0]   data;
   } tcw_res_type;

   function automatic logic [CELL_AW-1:0] cell_pos(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
      return CELL_AW'(row) * CELL_AW'(COLUMNS) + CELL_AW'(col);
   endfunction

endpackage

// ----- sv/tcw_req_if.sv -----
`timescale 1ns / 1ps

interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::MODE_W-1:0]    mode;
   logic [tcw_pkg::CHAR_W-1:0]    char_code;
   logic [tcw_pkg::COLOUR_W-1:0]  fore_color;
   logic [tcw_pkg::COLOUR_W-1:0]  bg_colour;
   logic [tcw_pkg::INDEX_W-1:0]   read_index;

   modport source (output valid, mode, char_code, fore_color, bg_colour, read_index,
                   input ready);
   modport sink   (input valid, mode, char_code, fore_color, bg_colour, read_index,
                   output ready);
endinterface

// ----- sv/tcw_rsp_if.sv -----
`timescale 1ns / 1ps

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::CURSOR_W-1:0]  cursor_position;
   logic [tcw_pkg::CELL_W-1:0]    cell_data;

   modport source (output valid, cursor_position, cell_data, input ready);
   modport sink   (input valid, cursor_position, cell_data, output ready);
endinterface

// ----- sv/tcw_ram.sv -----
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_q [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_q[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_q[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/tcw_ctrl.sv -----
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tcw_req_if.sink     req,
   input  logic        slot_free,
   output tcw_res_type res
);

   tcw_state_type       state_ff, state_in;
   logic [CELL_AW-1:0]  ptr_ff, ptr_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CELL_W-1:0]   data_ff, data_in;
   logic                pend_ff, pend_in;
   logic [CELL_AW-1:0]  pend_addr_ff, pend_addr_in;
   logic                init_ff, init_in;

   logic                accept;
   logic                index_ok;

   // character decode
   logic [COL_W:0]      col_inc;
   logic [COL_W:0]      col_tab;
   logic [COL_W-1:0]    put_col;
   logic [ROW_W-1:0]    put_row;
   logic                put_newline;
   logic                put_write;
   logic                put_scroll;

   // memory port
   logic                mem_we;
   logic [CELL_AW-1:0]  mem_waddr;
   logic [CELL_W-1:0]   mem_wdata;
   logic                mem_re;
   logic [CELL_AW-1:0]  mem_raddr;
   logic [CELL_W-1:0]   mem_rdata;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign accept   = req.valid && req.ready;
   assign index_ok = 32'(req.read_index) < 32'(CELL_COUNT);

   always_comb begin
      col_inc     = {1'b0, col_ff} + (COL_W+1)'(1);
      col_tab     = ({1'b0, col_ff} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
      put_col     = col_ff;
      put_newline = 1'b0;
      put_write   = 1'b0;
      case (req.char_code)
         CH_BS: begin
            if (col_ff != '0) begin
               put_col = col_ff - COL_W'(1);
            end
         end
         CH_TAB: begin
            if (col_tab >= (COL_W+1)'(COLUMNS)) begin
               put_newline = 1'b1;
            end else begin
               put_col = col_tab[COL_W-1:0];
            end
         end
         CH_LF: begin
            put_newline = 1'b1;
         end
         default: begin
            if (req.char_code >= CH_SPACE && req.char_code <= CH_LAST) begin
               put_write = 1'b1;
               if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                  put_newline = 1'b1;
               end else begin
                  put_col = col_inc[COL_W-1:0];
               end
            end
         end
      endcase
      put_scroll = put_newline && (row_ff == ROW_W'(ROWS - 1));
      put_row    = row_ff;
      if (put_newline) begin
         put_col = '0;
         if (!put_scroll) begin
            put_row = row_ff + ROW_W'(1);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.mode)
                  MODE_PUT:   state_in = put_scroll ? ST_SCROLL : ST_DONE;
                  MODE_CLEAR: state_in = ST_FILL;
                  MODE_READ:  state_in = index_ok ? ST_READ : ST_DONE;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_SCROLL: begin
            if (ptr_ff == SCROLL_END) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (ptr_ff == LAST_CELL) begin
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ptr_in       = ptr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      data_in      = data_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      init_in      = init_ff;
      mem_we       = 1'b0;
      mem_waddr    = cell_pos(row_ff, col_ff);
      mem_wdata    = {req.bg_colour, req.fore_color, req.char_code};
      mem_re       = 1'b0;
      mem_raddr    = CELL_AW'(req.read_index);
      req.ready    = (state_ff == ST_IDLE);
      res.valid    = 1'b0;
      res.cursor   = CURSOR_W'(cell_pos(row_ff, col_ff));
      res.data     = data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in = '0;
               ptr_in  = '0;
               pend_in = 1'b0;
               case (req.mode)
                  MODE_PUT: begin
                     col_in = put_col;
                     row_in = put_row;
                     mem_we = put_write;
                  end
                  MODE_CLEAR: begin
                     col_in = '0;
                     row_in = '0;
                  end
                  MODE_READ: begin
                     mem_re = index_ok;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            data_in = mem_rdata;
         end
         ST_SCROLL: begin
            // read one row below and write the registered read data back one row up
            if (ptr_ff != SCROLL_END) begin
               mem_re       = 1'b1;
               mem_raddr    = ptr_ff + CELL_AW'(COLUMNS);
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               ptr_in       = ptr_ff + CELL_AW'(1);
            end else begin
               pend_in = 1'b0;
            end
            mem_we    = pend_ff;
            mem_waddr = pend_addr_ff;
            mem_wdata = mem_rdata;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = BLANK_CELL;
            ptr_in    = ptr_ff + CELL_AW'(1);
            if (ptr_ff == LAST_CELL) begin
               init_in = 1'b0;
            end
         end
         ST_DONE: begin
            res.valid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         ptr_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= 1'b0;
         init_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      pend_addr_ff <= pend_addr_in;
   end

   // a fill sweep always writes blanks
   a_fill_blank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (mem_we && mem_wdata == BLANK_CELL))
      else $error("fill sweep without blank write");

   // scroll write-back lands on the row above the cell read in the previous cycle
   a_scroll_addr: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && state_ff == ST_SCROLL) |->
         (mem_we && mem_waddr == $past(ptr_ff)
                 && mem_waddr + CELL_AW'(COLUMNS) == $past(mem_raddr)))
      else $error("scroll write-back address mismatch");

   // no request taken until the reset clearing pass is over
   a_init_block: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !req.ready)
      else $error("request taken during clearing pass");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS)))
      else $error("cursor off screen");

endmodule

// ----- sv/text_console_writer.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake    Payload
// req       in   valid/ready  mode, char_code, fore_color, bg_colour, read_index
// rsp       out  valid/ready  cursor_position, cell_data
//
// Put character (no scroll) and read-out-of-range go straight to the result; a cell read
// first passes through the read state. Scroll moves the screen up a row, one cell moved
// per cycle through the single write port of the cell RAM, then blanks the bottom row.
// Clear blanks every cell. After reset a clearing pass blanks all CELL_COUNT (2000)
// cells of the RAM; req.ready stays low until it ends.
// One item in flight at a time; a finished result sits in the output register, so a
// new req transfer is taken while rsp is stalled, and only its completion waits.

module text_console_writer import tcw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req,
   tcw_rsp_if.source  rsp
);

   tcw_res_type         res;
   logic                slot_free;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [CELL_W-1:0]   rsp_data_ff, rsp_data_in;

   // sequencer, cursor state and cell RAM
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .slot_free (slot_free),
      .res       (res)
   );

   // output register frees up in the same cycle its transfer completes
   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_data_in   = rsp_data_ff;
      if (res.valid && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_cursor_in = res.cursor;
         rsp_data_in   = res.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.cursor_position = rsp_cursor_ff;
   assign rsp.cell_data       = rsp_data_ff;

endmodule

// ----- verif/text_console_writer_test.sv -----
`timescale 1ns / 1ps

module text_console_writer_test;
   import tcw_pkg::*;

   // Mode 3 is unused by the block: it must come back with the cursor and no data
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam int LIMIT_CYCLES = 3_000_000;  // every request a scroll, worst stalls, x5
   localparam int HOLD_CYCLES  = 400;        // long response hold-off
   localparam int TAIL_CYCLES  = 40;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor;
      logic [CELL_W-1:0]   data;
   } console_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcw_req_if req ();
   tcw_rsp_if rsp ();

   text_console_writer dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Screen model: its own copy of the cell store and the cursor
   // ------------------------------------------------------------------
   logic [CELL_W-1:0] screen_image [CELL_COUNT];
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   console_rsp_type   expected_rsps [$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  steady_flow    = 1'b0;  // no idling on either side while set
   int  hold_requests  = 0;     // bumped by the sequence, one long hold-off each
   int  holds_granted  = 0;
   int  rsp_stall_left = 0;

   function automatic int cursor_linear();
      return int'(cur_row) * COLUMNS + int'(cur_col);
   endfunction

   // Blank every cell and home the cursor (reset and clear-screen)
   function automatic void blank_image();
      for (int i = 0; i < CELL_COUNT; i++) screen_image[i] = BLANK_CELL;
      cur_col = '0;
      cur_row = '0;
   endfunction

   // Column 0 of the next row; off the bottom the whole screen moves up one row
   // and the bottom row comes back blank
   function automatic void advance_row();
      cur_col = '0;
      if (int'(cur_row) + 1 >= ROWS) begin
         for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            screen_image[i] = screen_image[i + COLUMNS];
         for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_image[i] = BLANK_CELL;
         cur_row = ROW_W'(ROWS - 1);
      end else begin
         cur_row = cur_row + 1'b1;
      end
   endfunction

   function automatic void apply_char(logic [CHAR_W-1:0] code, logic [COLOUR_W-1:0] fore,
                                      logic [COLOUR_W-1:0] back);
      int next_col;
      if (code == CH_BS) begin
         // backspace stops at the left margin
         if (cur_col != 0) cur_col = cur_col - 1'b1;
      end else if (code == CH_TAB) begin
         // next multiple of four; past the right margin it behaves as a line wrap
         next_col = (int'(cur_col) + 4) & ~3;
         if (next_col >= COLUMNS) advance_row();
         else cur_col = COL_W'(next_col);
      end else if (code == CH_LF) begin
         advance_row();
      end else if (code >= CH_SPACE && code <= CH_LAST) begin
         screen_image[cursor_linear()] = {back, fore, code};
         if (int'(cur_col) + 1 >= COLUMNS) advance_row();
         else cur_col = cur_col + 1'b1;
      end
      // any other code leaves everything as it was
   endfunction

   // Run one accepted request through the model and queue the response it owes
   function automatic void predict_console(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] code,
                                           logic [COLOUR_W-1:0] fore,
                                           logic [COLOUR_W-1:0] back,
                                           logic [INDEX_W-1:0] index);
      console_rsp_type want;
      want.data = '0;
      case (mode)
         MODE_PUT: begin
            apply_char(code, fore, back);
         end
         MODE_CLEAR: begin
            blank_image();
         end
         MODE_READ: begin
            // beyond the store the data stays zero
            if (index < CELL_COUNT) want.data = screen_image[index];
         end
         default: begin
         end
      endcase
      want.cursor = CURSOR_W'(cursor_linear());
      expected_rsps.push_back(want);
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting and response checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Every response transfer is matched against the oldest expectation
   always @(posedge clock) begin
      console_rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with none pending", rsp.cursor_position, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp.cursor_position !== want.cursor)
               report_mismatch("cursor_position", rsp.cursor_position, want.cursor);
            if (rsp.cell_data !== want.data)
               report_mismatch("cell_data", rsp.cell_data, want.data);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("watchdog expired after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Response side: random stalls, mostly short, now and then long, plus
   // the long hold-off on request; driven on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_requests != holds_granted) begin
         holds_granted  = hold_requests;
         rsp_stall_left = HOLD_CYCLES;
      end
      if (rsp_stall_left > 0) begin
         rsp.ready = 1'b0;
         rsp_stall_left--;
      end else if (steady_flow || $urandom_range(0, 99) < 70) begin
         rsp.ready = 1'b1;
      end else begin
         rsp.ready = 1'b0;
         if ($urandom_range(0, 9) == 0) rsp_stall_left = $urandom_range(10, 50);
         else rsp_stall_left = $urandom_range(0, 2);
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   function automatic int request_gap();
      int pick;
      if (steady_flow) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one request from a falling edge and hold it until the transfer;
   // valid stays high afterwards so back-to-back requests need no drop
   task automatic send_request(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] code,
                               logic [COLOUR_W-1:0] fore, logic [COLOUR_W-1:0] back,
                               logic [INDEX_W-1:0] index);
      int gap;
      gap = request_gap();
      @(negedge clock);
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.mode       = mode;
      req.char_code  = code;
      req.fore_color = fore;
      req.bg_colour  = back;
      req.read_index = index;
      req.valid      = 1'b1;
      do @(posedge clock); while (!req.ready);
      predict_console(mode, code, fore, back, index);
   endtask

   function automatic logic [COLOUR_W-1:0] any_colour();
      return COLOUR_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [INDEX_W-1:0] any_index();
      return INDEX_W'($urandom_range(0, 2047));
   endfunction

   function automatic logic [CHAR_W-1:0] any_printable();
      return CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
   endfunction

   // Unused fields carry random values so every bit of them toggles
   task automatic put_char(logic [CHAR_W-1:0] code, logic [COLOUR_W-1:0] fore,
                           logic [COLOUR_W-1:0] back);
      send_request(MODE_PUT, code, fore, back, any_index());
   endtask

   task automatic put_text_char();
      put_char(any_printable(), any_colour(), any_colour());
   endtask

   task automatic read_cell(int index);
      send_request(MODE_READ, CHAR_W'($urandom_range(0, 255)), any_colour(), any_colour(),
                   INDEX_W'(index));
   endtask

   task automatic clear_console();
      send_request(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)), any_colour(), any_colour(),
                   any_index());
   endtask

   // Mostly cells just behind the cursor, where the writes land, some anywhere,
   // a few past the end of the store
   function automatic int pick_read_index();
      int pick;
      int base;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         base = cursor_linear() - int'($urandom_range(0, COLUMNS + 5));
         return (base < 0) ? 0 : base;
      end
      if (pick < 90) return $urandom_range(0, CELL_COUNT - 1);
      return $urandom_range(CELL_COUNT, 2047);
   endfunction

   // Codes that the block must ignore, spread over all three ignored bands
   function automatic logic [CHAR_W-1:0] ignored_code();
      case ($urandom_range(0, 2))
         0: return CHAR_W'($urandom_range(0, CH_BS - 1));
         1: return CHAR_W'($urandom_range(CH_LF + 1, CH_SPACE - 1));
         default: return CHAR_W'($urandom_range(CH_LAST + 1, 255));
      endcase
   endfunction

   // One request of the random mix; clear is rare so the cursor reaches the
   // bottom row and newlines keep scrolling
   task automatic random_request();
      int pick;
      int sub;
      pick = $urandom_range(0, 999);
      sub  = $urandom_range(0, 99);
      if (pick < 5) begin
         clear_console();
      end else if (pick < 25) begin
         send_request(MODE_SPARE, CHAR_W'($urandom_range(0, 255)), any_colour(), any_colour(),
                      any_index());
      end else if (pick < 200) begin
         read_cell(pick_read_index());
      end else if (sub < 55) begin
         put_text_char();
      end else if (sub < 70) begin
         put_char(CH_LF, any_colour(), any_colour());
      end else if (sub < 78) begin
         put_char(CH_TAB, any_colour(), any_colour());
      end else if (sub < 86) begin
         put_char(CH_BS, any_colour(), any_colour());
      end else begin
         put_char(ignored_code(), any_colour(), any_colour());
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, each control code, ignored codes, reads out of range,
   // the unused mode and clear-screen
   task automatic test_directed_basics();
      logic [CHAR_W-1:0] dead_codes [6];
      dead_codes = '{8'd0, 8'd7, 8'd11, 8'd31, 8'd128, 8'd255};
      read_cell(0);                             // blank after the clearing pass
      put_char(CH_BS, 4'h0, 4'h0);              // backspace at column 0: no move
      put_char(CH_LAST, 4'h0, 4'h0);
      put_char(CH_SPACE, 4'hF, 4'hF);
      read_cell(0);
      read_cell(1);
      put_char(CH_TAB, 4'h3, 4'hC);             // column 2 -> 4
      put_char(CH_BS, 4'hA, 4'h5);              // back to 3
      put_char(8'h41, 4'hA, 4'h5);
      foreach (dead_codes[i]) put_char(dead_codes[i], 4'hF, 4'hF);
      put_char(CH_LF, 4'h1, 4'h2);
      read_cell(3);
      read_cell(LAST_CELL);
      read_cell(CELL_COUNT);                    // first index past the store
      read_cell(2047);
      send_request(MODE_SPARE, 8'hFF, 4'hF, 4'hF, {INDEX_W{1'b1}});
      clear_console();
      read_cell(0);
      read_cell(3);
   endtask

   // Wrap at the right margin by a printable character, then by a tab;
   // no idling on either side for this stretch
   task automatic test_row_wrap();
      logic [ROW_W-1:0] start_row;
      steady_flow = 1'b1;
      while (int'(cur_col) != COLUMNS - 4) put_char(CH_TAB, any_colour(), any_colour());
      repeat (4) put_text_char();
      read_cell(COLUMNS - 1);
      read_cell(COLUMNS - 4);
      repeat (3) put_text_char();
      start_row = cur_row;
      while (cur_row == start_row) begin
         if ($urandom_range(0, 4) == 0) read_cell(pick_read_index());
         else put_char(CH_TAB, any_colour(), any_colour());
      end
      read_cell(cursor_linear());
      steady_flow = 1'b0;
   endtask

   // Text and newlines until the bottom row, then lines that scroll the screen;
   // the line just moved up and the fresh bottom row are read back
   task automatic test_scrolling();
      int pick;
      while (int'(cur_row) != ROWS - 1) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) put_char(CH_LF, any_colour(), any_colour());
         else if (pick < 90) put_text_char();
         else read_cell(pick_read_index());
      end
      repeat (6) begin
         repeat ($urandom_range(1, 5)) put_text_char();
         put_char(CH_LF, any_colour(), any_colour());
         read_cell((ROWS - 2) * COLUMNS + int'($urandom_range(0, 5)));
         read_cell((ROWS - 1) * COLUMNS + int'($urandom_range(0, COLUMNS - 1)));
      end
   endtask

   // Responses held off for a long stretch while requests keep coming, so the
   // output register fills and the request side stalls
   task automatic test_output_backpressure();
      hold_requests++;
      repeat (12) random_request();
   endtask

   task automatic test_random_mix();
      repeat (125) random_request();
   endtask

   task automatic test_clear_and_reread();
      clear_console();
      read_cell(0);
      read_cell(LAST_CELL);
      put_text_char();
      read_cell(0);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req.valid      = 1'b0;
      req.mode       = MODE_PUT;
      req.char_code  = '0;
      req.fore_color = '0;
      req.bg_colour  = '0;
      req.read_index = '0;
      blank_image();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // the block blanks its store first; the first transfer waits on req.ready

      test_directed_basics();
      test_row_wrap();
      test_scrolling();
      test_output_backpressure();
      test_random_mix();
      test_clear_and_reread();

      @(negedge clock);
      req.valid = 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/tcw_pkg.sv
sv/tcw_req_if.sv
sv/tcw_rsp_if.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/text_console_writer.sv
verif/text_console_writer_test.sv
